// File: hdl/nds_pkg.sv
`default_nettype none

package nds_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_DELIMITER  = 3'd0;
  localparam logic [2:0] CFG_PAIR_COUNT = 3'd1;
  localparam logic [2:0] CFG_PAIR_ZERO  = 3'd2;
  localparam logic [2:0] CFG_PAIR_ONE   = 3'd3;
  localparam logic [2:0] CFG_PAIR_TWO   = 3'd4;
  localparam logic [2:0] CFG_PAIR_THREE = 3'd5;

  localparam int unsigned PAIR_REGS = 4;

  // reset values of the configuration registers
  localparam logic [7:0]  DELIMITER_RST  = 8'h2C;
  localparam logic [2:0]  PAIR_COUNT_RST = 3'd1;
  localparam logic [15:0] PAIR_ZERO_RST  = 16'h7B7D;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_beat_t;

  typedef struct packed {
    logic        is_split;
    logic [15:0] position;
    logic [15:0] column_index;
    logic [4:0]  nest_depth;
    logic        error_seen;
    logic        line_done;
    logic        line_ok;
  } out_beat_t;

  // shift command for the stack cell row
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  // result of the pair lookup for one byte
  typedef struct packed {
    logic [7:0] close_sym;
    logic       is_close;
  } pair_hit_t;

endpackage

`default_nettype wire

// File: hdl/nds_stack_cell.sv
`default_nettype none

module nds_stack_cell
  import nds_pkg::*;
(
  input  wire logic       clk_i,
  input  wire stk_ctl_t   ctl_i,
  input  wire logic [7:0] upper_i,
  input  wire logic [7:0] lower_i,
  output logic      [7:0] data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  // push moves entries away from the top, pop moves them toward it
  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = upper_i;
    end else if (ctl_i.pop) begin
      data_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: hdl/nds_pair_lookup.sv
`default_nettype none

module nds_pair_lookup
  import nds_pkg::*;
#(
  parameter int unsigned PAIR_SLOTS = 4
) (
  input  wire logic [7:0]                  char_i,
  input  wire logic [2:0]                  pair_count_i,
  input  wire logic [PAIR_REGS-1:0][15:0]  pairs_i,
  output pair_hit_t                        hit_o
);

  localparam logic [2:0] SLOTS_L = 3'(PAIR_SLOTS);

  logic [2:0] active;

  assign active = (pair_count_i > SLOTS_L) ? SLOTS_L : pair_count_i;

  always_comb begin
    logic [7:0] open_sym;
    logic [7:0] close_sym;
    hit_o = '0;
    for (int i = 0; i < PAIR_SLOTS; i++) begin
      open_sym  = pairs_i[i][15:8];
      close_sym = (pairs_i[i][7:0] != 8'h00) ? pairs_i[i][7:0] : open_sym;
      if (3'(i) < active && open_sym != 8'h00) begin
        // later pair wins for the same opening
        if (open_sym == char_i) begin
          hit_o.close_sym = close_sym;
        end
        if (close_sym == char_i) begin
          hit_o.is_close = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/nested_delimiter_splitter.sv
`default_nettype none
// nested_delimiter_splitter
// Splits a line into columns, one byte a beat, while matching nested
// opening/closing symbol pairs. Input beats carry char_in and end_of_line;
// every input beat yields exactly one output beat with the split flag,
// byte position, column index, nesting depth and error/line status.
// Both streams use valid/stall: a beat moves when valid is high and stall
// is low. Configuration writes use cfg_valid_i/cfg_ready_o (always ready)
// with a register index and data; write them only while the block is idle.
// A byte's result is registered in the output register, or in the skid
// register on a stall. One byte per cycle while in_stall_o is low, set
// by the stack update; the stack is a row of shift cells, top in cell 0.
// When the receiver stalls, the output register holds its beat and one
// more result lands in a skid register; only then is in_stall_o raised.
// Reset clears line state, the output/skid valids and loads the register
// defaults (delimiter ',' and one pair "{}"). Stack cells are not cleared:
// only entries below the current depth are ever compared.
module nested_delimiter_splitter
  import nds_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned PAIR_SLOTS  = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_beat_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_beat_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(STACK_DEPTH);

  // configuration registers
  logic [7:0]                  delimiter_q;
  logic [2:0]                  pair_count_q;
  logic [PAIR_REGS-1:0][15:0]  pairs_q;

  // line state
  logic [LVL_W-1:0] level_q, level_d;
  logic             err_q, err_d;
  logic [15:0]      pos_q, pos_d;
  logic [15:0]      col_q, col_d;

  // output register and skid
  out_beat_t out_q, skid_q, result;
  logic      out_valid_q, skid_valid_q;

  logic       accept, out_take;
  stk_ctl_t   stk_ctl;
  pair_hit_t  hit;
  logic [7:0] top_sym;
  logic [7:0] cell_data [STACK_DEPTH];
  logic [LVL_W+4:0] level_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // config write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q  <= DELIMITER_RST;
      pair_count_q <= PAIR_COUNT_RST;
      pairs_q      <= {16'h0000, 16'h0000, 16'h0000, PAIR_ZERO_RST};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DELIMITER:  delimiter_q  <= cfg_data_i[7:0];
        CFG_PAIR_COUNT: pair_count_q <= cfg_data_i[2:0];
        CFG_PAIR_ZERO:  pairs_q[0]   <= cfg_data_i;
        CFG_PAIR_ONE:   pairs_q[1]   <= cfg_data_i;
        CFG_PAIR_TWO:   pairs_q[2]   <= cfg_data_i;
        CFG_PAIR_THREE: pairs_q[3]   <= cfg_data_i;
        default: ; // unused indexes are ignored
      endcase
    end
  end

  nds_pair_lookup #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_lookup (
    .char_i       (in_data_i.char_in),
    .pair_count_i (pair_count_q),
    .pairs_i      (pairs_q),
    .hit_o        (hit)
  );

  assign top_sym = cell_data[0];

  // per-byte decision, checks in priority order
  always_comb begin
    level_d = level_q;
    err_d   = err_q;
    col_d   = col_q;
    pos_d   = pos_q;
    stk_ctl = '0;
    result  = '0;

    if (!err_q) begin
      if (level_q == '0 && in_data_i.char_in == delimiter_q) begin
        // split at depth zero
        result.is_split = 1'b1;
        if (col_q < COUNT_MAX) begin
          col_d = col_q + 16'd1;
        end
      end else if (level_q != '0 && in_data_i.char_in == top_sym) begin
        // matching close pops the top
        stk_ctl.pop = accept;
        level_d     = level_q - LVL_W'(1);
      end else if (hit.close_sym != 8'h00) begin
        if (level_q < DEPTH_L) begin
          stk_ctl.push = accept;
          level_d      = level_q + LVL_W'(1);
        end else begin
          err_d = 1'b1; // overflow
        end
      end else if (hit.is_close) begin
        err_d = 1'b1; // stray closing symbol
      end
    end

    level_ext           = {5'b00000, level_d};
    result.position     = pos_q;
    result.column_index = col_q;
    result.nest_depth   = level_ext[4:0];
    result.error_seen   = err_d;
    result.line_done    = in_data_i.end_of_line;
    result.line_ok      = in_data_i.end_of_line && !err_d && level_d == '0;

    if (in_data_i.end_of_line) begin
      level_d = '0;
      err_d   = 1'b0;
      pos_d   = '0;
      col_d   = '0;
    end else if (pos_q < COUNT_MAX) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      err_q   <= 1'b0;
      pos_q   <= '0;
      col_q   <= '0;
    end else if (accept) begin
      level_q <= level_d;
      err_q   <= err_d;
      pos_q   <= pos_d;
      col_q   <= col_d;
    end
  end

  // stack row: cell 0 is the top, new symbols enter there
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [7:0] upper, lower;
    if (g == 0) begin : g_first
      assign upper = hit.close_sym;
    end else begin : g_mid_up
      assign upper = cell_data[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign lower = 8'h00;
    end else begin : g_mid_dn
      assign lower = cell_data[g+1];
    end
    nds_stack_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (stk_ctl),
      .upper_i (upper),
      .lower_i (lower),
      .data_o  (cell_data[g])
    );
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

endmodule

`default_nettype wire
